### rtl/elsa_pkg.sv
// ============================================================================
// elsa_pkg
// Shared types and constants for the edge list to sorted adjacency block.
// ============================================================================
package elsa_pkg;

    // Default sizes of the adjacency table
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_DEGREE   = 16;
    localparam int DEF_MAX_EDGES    = 4096;

    // Item operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Register index of vertex_count
    localparam logic REG_VERTEX_COUNT = 1'b0;

    // Strobes from the sequencer to the row store
    typedef struct packed {
        logic fill_rd;
        logic fill_wr;
        logic row_rd;
        logic row_wr;
    } t_mem_ctl;

endpackage

### rtl/elsa_mem.sv
// ============================================================================
// elsa_mem
// Row store: per-row fill counts and the entry array, each with one write
// port and one registered read port.
// ============================================================================
module elsa_mem #(
    parameter int VW   = 10,
    parameter int DGW  = 5,
    parameter int AW   = 14,
    parameter int ROWW = 22
) (
    input  logic                i_clk,
    input  elsa_pkg::t_mem_ctl  i_ctl,
    input  logic [VW-1:0]       i_fill_raddr,
    input  logic [VW-1:0]       i_fill_waddr,
    input  logic [DGW-1:0]      i_fill_wdata,
    output logic [DGW-1:0]      o_fill_rdata,
    input  logic [AW-1:0]       i_row_raddr,
    input  logic [AW-1:0]       i_row_waddr,
    input  logic [ROWW-1:0]     i_row_wdata,
    output logic [ROWW-1:0]     o_row_rdata
);
    import elsa_pkg::*;

    localparam int FILL_DEPTH = 2 ** VW;
    localparam int ROW_DEPTH  = 2 ** AW;

    logic [DGW-1:0]  fill_mem [FILL_DEPTH];
    logic [ROWW-1:0] row_mem  [ROW_DEPTH];
    logic [DGW-1:0]  r_fill_q;
    logic [ROWW-1:0] r_row_q;

    // fill count store
    always_ff @(posedge i_clk) begin
        if (i_ctl.fill_wr) begin
            fill_mem[i_fill_waddr] <= i_fill_wdata;
        end
        if (i_ctl.fill_rd) begin
            r_fill_q <= fill_mem[i_fill_raddr];
        end
    end

    // entry store, {neighbor, edge id} per word
    always_ff @(posedge i_clk) begin
        if (i_ctl.row_wr) begin
            row_mem[i_row_waddr] <= i_row_wdata;
        end
        if (i_ctl.row_rd) begin
            r_row_q <= row_mem[i_row_raddr];
        end
    end

    assign o_fill_rdata = r_fill_q;
    assign o_row_rdata  = r_row_q;

endmodule

### rtl/edge_list_to_sorted_adjacency.sv
// ============================================================================
// edge_list_to_sorted_adjacency
// Builds a sorted per-vertex adjacency table from a stream of edges.
//
// One item is worked at a time, and s_axis_tready is high only while the block
// is idle.
// An add works each endpoint in turn: it fetches the row count, then moves
// entries up in the row one at a time (at most MAX_DEGREE-1) and drops the
// new entry in. A full row drops the entry for that endpoint. An acknowledge
// follows both endpoints.
// A read fetches the row count, then reads and hands over each entry in
// turn; an empty row gives one empty result.
// A clear, and the pass after reset, walk the fill count store one row per
// cycle, over all MAX_VERTICES rows; only the clear is acknowledged.
// A rejected vertex or an unused op goes straight to the acknowledge.
// A stalled output holds the sequencer until the result register is free.
// The pace is set by the single read and write port of the entry store and
// by the one compare unit of the insertion loop.
// Results sit in an output register, so the next item can be taken while the
// last result waits.
// ============================================================================
module edge_list_to_sorted_adjacency #(
    parameter int MAX_VERTICES = elsa_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = elsa_pkg::DEF_MAX_DEGREE,
    parameter int MAX_EDGES    = elsa_pkg::DEF_MAX_EDGES,
    localparam int VW    = $clog2(MAX_VERTICES),
    localparam int EW    = $clog2(MAX_EDGES),
    localparam int DGW   = $clog2(MAX_DEGREE + 1),
    localparam int IN_W  = 3 * VW + EW,
    localparam int IN_TW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W = VW + EW + DGW + 1,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // items in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // end_vertex_a, end_vertex_b, edge_number, row_vertex (low to high)
    input  logic [IN_TW-1:0]  s_axis_tdata,
    // op
    input  logic [1:0]        s_axis_tuser,
    // results out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // neighbor_vertex, via_edge, row_degree, overflow_seen (low to high)
    output logic [OUT_TW-1:0] m_axis_tdata,
    // entry_valid
    output logic              m_axis_tuser,
    // last_entry
    output logic              m_axis_tlast
);
    import elsa_pkg::*;

    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int AW   = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int ROWW = VW + EW;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_FILL_RD  = 8'b0000_0100,
        S_FILL_CHK = 8'b0000_1000,
        S_SHIFT    = 8'b0001_0000,
        S_RD_ISSUE = 8'b0010_0000,
        S_RD_DATA  = 8'b0100_0000,
        S_ACK      = 8'b1000_0000
    } t_state;

    // control registers
    t_state         r_state, n_state;
    logic [CW-1:0]  r_vcount;
    logic           r_overflow, n_overflow;
    logic [VW-1:0]  r_clr_idx, n_clr_idx;
    logic           r_clr_ack, n_clr_ack;
    logic           r_out_vld, n_out_vld;

    // working registers
    logic [VW-1:0]  r_a, n_a;
    logic [VW-1:0]  r_b, n_b;
    logic [EW-1:0]  r_eid, n_eid;
    logic [VW-1:0]  r_vtx, n_vtx;
    logic [VW-1:0]  r_nb, n_nb;
    logic           r_phase, n_phase;
    logic           r_is_read, n_is_read;
    logic [AW-1:0]  r_base, n_base;
    logic [DGW-1:0] r_idx, n_idx;
    logic [DGW-1:0] r_n, n_n;

    // output register
    logic [VW-1:0]  r_out_nb, n_out_nb;
    logic [EW-1:0]  r_out_eid, n_out_eid;
    logic           r_out_entry, n_out_entry;
    logic [DGW-1:0] r_out_deg, n_out_deg;
    logic           r_out_last, n_out_last;
    logic           r_out_ovf, n_out_ovf;

    // store interface
    t_mem_ctl        mem_ctl;
    logic [VW-1:0]   fill_waddr;
    logic [DGW-1:0]  fill_wdata;
    logic [DGW-1:0]  fill_q;
    logic [AW-1:0]   row_raddr;
    logic [AW-1:0]   row_waddr;
    logic [ROWW-1:0] row_wdata;
    logic [ROWW-1:0] row_q;

    logic           cfg_wr;
    logic [CW-1:0]  vlimit;
    logic           in_xfer;
    logic           out_free;
    logic [1:0]     in_op;
    logic [VW-1:0]  in_a;
    logic [VW-1:0]  in_b;
    logic [EW-1:0]  in_eid;
    logic [VW-1:0]  in_rv;
    logic           row_gt;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT);
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(r_vcount) : 32'd0;
    assign vlimit = (r_vcount > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : r_vcount;

    // ------------------------------------------------------------------
    // stream unpacking
    // ------------------------------------------------------------------
    assign in_op  = s_axis_tuser;
    assign in_a   = s_axis_tdata[VW-1:0];
    assign in_b   = s_axis_tdata[2*VW-1:VW];
    assign in_eid = s_axis_tdata[2*VW+EW-1:2*VW];
    assign in_rv  = s_axis_tdata[3*VW+EW-1:2*VW+EW];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;

    // shared compare: stored entry sorts after the new one
    assign row_gt = row_q > {r_nb, r_eid};

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_overflow  = r_overflow;
        n_clr_idx   = r_clr_idx;
        n_clr_ack   = r_clr_ack;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_a         = r_a;
        n_b         = r_b;
        n_eid       = r_eid;
        n_vtx       = r_vtx;
        n_nb        = r_nb;
        n_phase     = r_phase;
        n_is_read   = r_is_read;
        n_base      = r_base;
        n_idx       = r_idx;
        n_n         = r_n;
        n_out_nb    = r_out_nb;
        n_out_eid   = r_out_eid;
        n_out_entry = r_out_entry;
        n_out_deg   = r_out_deg;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        mem_ctl    = '0;
        fill_waddr = r_vtx;
        fill_wdata = '0;
        row_raddr  = r_base + AW'(r_idx);
        row_waddr  = r_base + AW'(r_idx);
        row_wdata  = row_q;

        case (r_state)
            // walk the fill store, zeroing one row count per cycle
            S_CLEAR: begin
                mem_ctl.fill_wr = 1'b1;
                fill_waddr      = r_clr_idx;
                fill_wdata      = '0;
                if (r_clr_idx == VW'(MAX_VERTICES - 1)) begin
                    n_state = r_clr_ack ? S_ACK : S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end

            S_IDLE: begin
                if (in_xfer) begin
                    n_a       = in_a;
                    n_b       = in_b;
                    n_eid     = in_eid;
                    n_phase   = 1'b0;
                    n_is_read = 1'b0;
                    case (in_op)
                        OP_ADD: begin
                            if (CW'(in_a) >= vlimit || CW'(in_b) >= vlimit) begin
                                n_overflow = 1'b1;
                                n_state    = S_ACK;
                            end else begin
                                n_vtx   = in_a;
                                n_nb    = in_b;
                                n_state = S_FILL_RD;
                            end
                        end
                        OP_READ: begin
                            n_is_read = 1'b1;
                            if (CW'(in_rv) >= vlimit) begin
                                n_overflow = 1'b1;
                                n_state    = S_ACK;
                            end else begin
                                n_vtx   = in_rv;
                                n_state = S_FILL_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_clr_idx = '0;
                            n_clr_ack = 1'b1;
                            n_state   = S_CLEAR;
                        end
                        default: begin
                            n_state = S_ACK;
                        end
                    endcase
                end
            end

            // fetch the row count, form the row base address
            S_FILL_RD: begin
                mem_ctl.fill_rd = 1'b1;
                n_base          = AW'(r_vtx) * AW'(MAX_DEGREE);
                n_state         = S_FILL_CHK;
            end

            S_FILL_CHK: begin
                n_n = fill_q;
                if (r_is_read) begin
                    n_idx   = '0;
                    n_state = (fill_q == '0) ? S_ACK : S_RD_ISSUE;
                end else if (fill_q >= DGW'(MAX_DEGREE)) begin
                    // row full: drop this entry
                    n_overflow = 1'b1;
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        n_vtx   = r_b;
                        n_nb    = r_a;
                        n_state = S_FILL_RD;
                    end else begin
                        n_state = S_ACK;
                    end
                end else begin
                    // start from the tail, prefetch the last entry
                    n_idx          = fill_q;
                    mem_ctl.row_rd = (fill_q != '0);
                    row_raddr      = r_base + AW'(fill_q) - AW'(1);
                    n_state        = S_SHIFT;
                end
            end

            // one entry per cycle: move it up, or drop the new one in
            S_SHIFT: begin
                mem_ctl.row_wr = 1'b1;
                row_waddr      = r_base + AW'(r_idx);
                if (r_idx != '0 && row_gt) begin
                    row_wdata      = row_q;
                    n_idx          = r_idx - 1'b1;
                    mem_ctl.row_rd = (r_idx > DGW'(1));
                    row_raddr      = r_base + AW'(r_idx) - AW'(2);
                end else begin
                    row_wdata       = {r_nb, r_eid};
                    mem_ctl.fill_wr = 1'b1;
                    fill_waddr      = r_vtx;
                    fill_wdata      = r_n + 1'b1;
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        n_vtx   = r_b;
                        n_nb    = r_a;
                        n_state = S_FILL_RD;
                    end else begin
                        n_state = S_ACK;
                    end
                end
            end

            S_RD_ISSUE: begin
                mem_ctl.row_rd = 1'b1;
                row_raddr      = r_base + AW'(r_idx);
                n_state        = S_RD_DATA;
            end

            // hand one row entry to the output register
            S_RD_DATA: begin
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_nb    = row_q[ROWW-1:EW];
                    n_out_eid   = row_q[EW-1:0];
                    n_out_entry = 1'b1;
                    n_out_deg   = r_n;
                    n_out_last  = (r_idx + 1'b1 == r_n);
                    n_out_ovf   = r_overflow;
                    if (r_idx + 1'b1 == r_n) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD_ISSUE;
                    end
                end
            end

            // acknowledge or empty row result
            S_ACK: begin
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_nb    = '0;
                    n_out_eid   = '0;
                    n_out_entry = 1'b0;
                    n_out_deg   = '0;
                    n_out_last  = 1'b1;
                    n_out_ovf   = r_overflow;
                    n_clr_ack   = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_vcount   <= CW'(MAX_VERTICES);
            r_overflow <= 1'b0;
            r_clr_idx  <= '0;
            r_clr_ack  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
            r_clr_idx  <= n_clr_idx;
            r_clr_ack  <= n_clr_ack;
            r_out_vld  <= n_out_vld;
            if (cfg_wr) begin
                r_vcount <= pwdata[CW-1:0];
            end
        end
    end

    // working and output payload
    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_eid       <= n_eid;
        r_vtx       <= n_vtx;
        r_nb        <= n_nb;
        r_phase     <= n_phase;
        r_is_read   <= n_is_read;
        r_base      <= n_base;
        r_idx       <= n_idx;
        r_n         <= n_n;
        r_out_nb    <= n_out_nb;
        r_out_eid   <= n_out_eid;
        r_out_entry <= n_out_entry;
        r_out_deg   <= n_out_deg;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

    // ------------------------------------------------------------------
    // row store
    // ------------------------------------------------------------------
    elsa_mem #(
        .VW   (VW),
        .DGW  (DGW),
        .AW   (AW),
        .ROWW (ROWW)
    ) u_mem (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_fill_raddr (r_vtx),
        .i_fill_waddr (fill_waddr),
        .i_fill_wdata (fill_wdata),
        .o_fill_rdata (fill_q),
        .i_row_raddr  (row_raddr),
        .i_row_waddr  (row_waddr),
        .i_row_wdata  (row_wdata),
        .o_row_rdata  (row_q)
    );

    // ------------------------------------------------------------------
    // result stream
    // ------------------------------------------------------------------
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TW'({r_out_ovf, r_out_deg, r_out_eid, r_out_nb});
    assign m_axis_tuser  = r_out_entry;
    assign m_axis_tlast  = r_out_last;

endmodule

### rtl/elsa_checker.sv
// ============================================================================
// elsa_checker
// Port-level checks for the adjacency builder, bound to the top level.
// ============================================================================
module elsa_checker #(
    parameter int MAX_VERTICES = elsa_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = elsa_pkg::DEF_MAX_DEGREE,
    parameter int MAX_EDGES    = elsa_pkg::DEF_MAX_EDGES,
    localparam int VW     = $clog2(MAX_VERTICES),
    localparam int EW     = $clog2(MAX_EDGES),
    localparam int DGW    = $clog2(MAX_DEGREE + 1),
    localparam int OUT_W  = VW + EW + DGW + 1,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_TW-1:0] m_axis_tdata,
    input logic              m_axis_tuser,
    input logic              m_axis_tlast
);
    import elsa_pkg::*;

    // the clearing pass follows reset, so no transfer is taken right away
    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("input ready right after reset");

    // one item at a time: never ready in the cycle after a transfer in
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken back to back");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // a result without an entry is a lone, zeroed final result
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tlast && (m_axis_tdata[VW+EW+DGW-1:0] == '0))
        else $error("empty result not zeroed or not last");

    // an entry comes from a row that holds at least one entry
    a_entry_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[VW+EW+DGW-1:VW+EW] != '0))
        else $error("entry with zero row degree");

endmodule

bind edge_list_to_sorted_adjacency elsa_checker #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE),
    .MAX_EDGES    (MAX_EDGES)
) u_elsa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
